### rtl/absc_pkg.sv
// Shared types and codes for the authorized bucket selection check.
package absc_pkg;

  // Action codes of an input word.
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_RECORD = 1'b1;

  // Status codes of a result word.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_COUNTS   = 3'd1;
  localparam logic [2:0] ST_ZERO_GEN = 3'd2;
  localparam logic [2:0] ST_RANGE    = 3'd3;
  localparam logic [2:0] ST_DUP      = 3'd4;
  localparam logic [2:0] ST_REFUSED  = 3'd5;

  // Input word.
  typedef struct packed {
    logic        action;
    logic [31:0] node_index;
    logic [31:0] node_generation;
    logic [7:0]  auth_bucket;
    logic [7:0]  package_slot;
    logic        last;
  } item_t;

  // Result word.
  typedef struct packed {
    logic [3:0] selected_bucket;
    logic [2:0] status;
    logic       final_res;
  } result_t;

  // One stored table entry.
  typedef struct packed {
    logic [63:0] ref_val;
    logic [7:0]  bucket;
    logic [7:0]  slot;
    logic [2:0]  err;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic scan_en;
    logic finish;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic item_is_load;
    logic new_load_full;
    logic scan_done;
    logic out_free;
  } ctl_stat_t;

endpackage

### rtl/absc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module absc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/absc_ctrl.sv
// Controller state machine: accept a word, scan the table, finish the word.
module absc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  absc_pkg::ctl_stat_t   stat,
  output absc_pkg::ctl_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and command decode.
  always_comb begin
    state_next  = state;
    item_ready  = 1'b0;
    cmd         = '0;
    case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.accept = 1'b1;
          // A load into a full table only sets the overflow flag.
          state_next = stat.new_load_full ? S_IDLE : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (stat.scan_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        // A record needs a free output register; a load only writes the table.
        if (stat.item_is_load || stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/absc_datapath.sv
// Datapath: entry table, scan accumulators, counters and output register.
module absc_datapath #(
  parameter int MAX_ENTRIES = 16,
  parameter int MAX_RECORDS = 65535
) (
  input  logic                  clk,
  input  logic                  rst,
  input  absc_pkg::item_t       item,
  input  absc_pkg::ctl_cmd_t    cmd,
  output absc_pkg::ctl_stat_t   stat,
  output logic                  result_valid,
  input  logic                  result_ready,
  output absc_pkg::result_t     result
);

  localparam int AW    = $clog2(MAX_ENTRIES);
  localparam int CW    = $clog2(MAX_ENTRIES + 1);
  localparam int RCW   = $clog2(MAX_RECORDS + 2);
  localparam int CMPW  = (CW > 8) ? CW : 8;
  localparam int EW    = $bits(absc_pkg::entry_t);

  absc_pkg::item_t  item_q;
  logic [CW-1:0]    entry_count;
  logic             overflow;
  logic [RCW-1:0]   rec_count;
  logic             rec_err;
  logic [CW-1:0]    scan_addr;
  logic             rd_pend;
  logic             dup;
  logic             matched;
  logic [3:0]       match_bucket;
  logic [2:0]       tstat;

  absc_pkg::entry_t rd_entry;
  absc_pkg::entry_t wr_entry;
  logic [EW-1:0]    rd_data;
  logic             ram_we;
  logic             issue;
  logic [63:0]      item_ref;
  logic             ref_hit;
  logic             out_of_range;
  logic [RCW-1:0]   rec_count_next;
  logic             refused;
  logic             rec_err_next;
  logic [2:0]       status_next;

  // Entry table.
  absc_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (entry_count[AW-1:0]),
    .wdata (wr_entry),
    .raddr (scan_addr[AW-1:0]),
    .rdata (rd_data)
  );

  assign rd_entry = absc_pkg::entry_t'(rd_data);
  assign item_ref = {item_q.node_generation, item_q.node_index};
  assign issue    = cmd.scan_en && (scan_addr < entry_count);

  // Compare the entry read last cycle against the held word.
  assign ref_hit      = (rd_entry.ref_val == item_ref);
  assign out_of_range = (CMPW'(rd_entry.bucket) >= CMPW'(entry_count)) ||
                        (CMPW'(rd_entry.slot) >= CMPW'(entry_count));

  // New table entry built from the held load word.
  always_comb begin
    wr_entry.ref_val = item_ref;
    wr_entry.bucket  = item_q.auth_bucket;
    wr_entry.slot    = item_q.package_slot;
    if (item_q.node_generation == 32'd0) begin
      wr_entry.err = absc_pkg::ST_ZERO_GEN;
    end else if (dup) begin
      wr_entry.err = absc_pkg::ST_DUP;
    end else begin
      wr_entry.err = absc_pkg::ST_OK;
    end
  end

  assign ram_we = cmd.finish && (item_q.action == absc_pkg::ACT_LOAD);

  // Record verdict, with bad counts first, then the table check, then records.
  always_comb begin
    rec_count_next = (rec_count <= RCW'(MAX_RECORDS)) ? rec_count + 1'b1 : rec_count;
    refused        = (item_q.node_generation == 32'd0) || !matched;
    rec_err_next   = rec_err || refused;
    if ((rec_count_next > RCW'(MAX_RECORDS)) || (entry_count < CW'(2)) || overflow) begin
      status_next = absc_pkg::ST_COUNTS;
    end else if (tstat != absc_pkg::ST_OK) begin
      status_next = tstat;
    end else if (rec_err_next) begin
      status_next = absc_pkg::ST_REFUSED;
    end else begin
      status_next = absc_pkg::ST_OK;
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.item_is_load  = (item_q.action == absc_pkg::ACT_LOAD);
    stat.new_load_full = (item.action == absc_pkg::ACT_LOAD) &&
                         (entry_count >= CW'(MAX_ENTRIES));
    stat.scan_done     = !(scan_addr < entry_count) && !rd_pend;
    stat.out_free      = !result_valid || result_ready;
  end

  // Held word and scan accumulators.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_q       <= item;
      scan_addr    <= '0;
      dup          <= 1'b0;
      matched      <= 1'b0;
      match_bucket <= '0;
      tstat        <= absc_pkg::ST_OK;
    end else begin
      if (issue) begin
        scan_addr <= scan_addr + 1'b1;
      end
      if (rd_pend) begin
        if (ref_hit || (rd_entry.bucket == item_q.auth_bucket) ||
            (rd_entry.slot == item_q.package_slot)) begin
          dup <= 1'b1;
        end
        if (ref_hit && !matched) begin
          matched      <= 1'b1;
          match_bucket <= rd_entry.bucket[3:0];
        end
        if (tstat == absc_pkg::ST_OK) begin
          if (rd_entry.err == absc_pkg::ST_ZERO_GEN) begin
            tstat <= absc_pkg::ST_ZERO_GEN;
          end else if (out_of_range) begin
            tstat <= absc_pkg::ST_RANGE;
          end else if (rd_entry.err == absc_pkg::ST_DUP) begin
            tstat <= absc_pkg::ST_DUP;
          end
        end
      end
    end
  end

  // Counters, flags and the read-pending marker.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      overflow    <= 1'b0;
      rec_count   <= '0;
      rec_err     <= 1'b0;
      rd_pend     <= 1'b0;
    end else begin
      rd_pend <= issue;
      if (cmd.accept && stat.new_load_full) begin
        overflow <= 1'b1;
      end
      if (cmd.finish) begin
        if (item_q.action == absc_pkg::ACT_LOAD) begin
          entry_count <= entry_count + 1'b1;
        end else if (item_q.last) begin
          entry_count <= '0;
          overflow    <= 1'b0;
          rec_count   <= '0;
          rec_err     <= 1'b0;
        end else begin
          rec_count <= rec_count_next;
          rec_err   <= rec_err_next;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.finish && (item_q.action == absc_pkg::ACT_RECORD)) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && (item_q.action == absc_pkg::ACT_RECORD)) begin
      result.selected_bucket <= refused ? 4'd0 : match_bucket;
      result.status          <= status_next;
      result.final_res       <= item_q.last;
    end
  end

endmodule

### rtl/authorized_bucket_selection_check.sv
// Top level of the authorized bucket selection check.
//
//  Channel | Signals                            | Word
//  --------+------------------------------------+-------------------------------
//  input   | item_valid, item_ready, item       | load entry or selection record
//  output  | result_valid, result_ready, result | bucket, status, final flag
//
// A word is accepted, the table is read entry by entry through its registered
// port, the last entry read is compared, the scan ends, and then the table or
// the result is written; on an empty table the read and compare steps drop out.
// A load into a full table is not scanned and only sets the overflow flag.
// Reset clears counters and flags; only entries below the fill count are read.
// A record waits in its last cycle while the output register holds an untaken word.
module authorized_bucket_selection_check #(
  parameter int MAX_ENTRIES = 16,
  parameter int MAX_RECORDS = 65535
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  absc_pkg::item_t     item,
  output logic                result_valid,
  input  logic                result_ready,
  output absc_pkg::result_t   result
);

  absc_pkg::ctl_cmd_t  cmd;
  absc_pkg::ctl_stat_t stat;

  // Controller.
  absc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Datapath.
  absc_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_RECORDS (MAX_RECORDS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // The table is never scanned while a new word may be taken.
  a_no_scan_when_ready: assert property (@(posedge clk) disable iff (rst)
    item_ready |-> !cmd.scan_en)
    else $error("scan active while accepting");

  // Accepting and finishing never coincide.
  a_accept_not_finish: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |-> !cmd.finish)
    else $error("accept during finish");

  // After a word is finished the block is ready for the next one.
  a_ready_after_finish: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> item_ready)
    else $error("not ready after finish");

  // Only defined status codes leave the block.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.status <= absc_pkg::ST_REFUSED))
    else $error("undefined status code");

endmodule
